// File: src/cls_pkg.sv
// Shared types, constants and codes for the compacting list store.
// Used by the cell, the top level and the port checker; depends on nothing.
package cls_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int OUT_W    = 40;  // element and count, padded to whole bytes

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_DUMP   = 2'd2
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_APPEND,
		CELL_REMOVE,
		CELL_ROTATE
	} cell_op_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cell_op_t           op;
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   fill;
	} cell_ctl_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_DUMP
	} fsm_t;

endpackage

// File: src/cls_cell.sv
// One storage cell of the list chain: holds a single entry and trades it with
// its upper neighbor on remove and dump. Depends on cls_pkg.
module cls_cell
	import cls_pkg::*;
(
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [IDX_W-1:0]   idx,
	input  logic [VALUE_W-1:0] up_data,
	input  logic [VALUE_W-1:0] head_data,
	input  logic               above_in,
	input  logic               below_in,
	output logic               above_out,
	output logic               below_out,
	output logic [VALUE_W-1:0] data
);

	logic [VALUE_W-1:0] data_q;
	logic [CNT_W-1:0]   pos;
	logic               valid;
	logic               match;
	logic               shift;

	assign pos   = CNT_W'(idx);
	assign valid = pos < ctl.fill;
	assign match = valid && (data_q == ctl.value);

	// A match above this cell travels down, one at or below travels up.
	// This cell moves on remove when the last match sits at or below it.
	assign above_out = match | above_in;
	assign below_out = match | below_in;
	assign shift     = below_out & ~above_in;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_APPEND: begin
				if (pos == ctl.fill)
					data_q <= ctl.value;
			end
			CELL_REMOVE: begin
				if (shift)
					data_q <= up_data;
			end
			CELL_ROTATE: begin
				// The head wraps around to the tail so the list is whole again
				// once every entry has been rotated.
				if (pos == CNT_W'(ctl.fill - 1'b1))
					data_q <= head_data;
				else if (valid)
					data_q <= up_data;
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

// File: src/compacting_list_store.sv
// Top level of the compacting list store: controller, dump sequencer, result
// register and the chain of cls_cell instances. Depends on cls_pkg.
//
//  channel | dir | tdata                         | tuser      | tlast
//  s_axis  | in  | value[31:0]                   | action[1:0]| -
//  m_axis  | out | element[31:0], count[36:32]   | status[1:0]| last of run
//
// Append and remove finish in the cycle the item is taken; the chain shifts
// in place, so one item per cycle while results are taken.
// A dump of n entries emits them one item per cycle while results are taken,
// by rotating the chain through cell 0; no input is taken meanwhile.
// Reset clears the fill count and the control state; entries are not cleared.
// A stalled result holds; a new input is taken in the cycle the held result
// leaves.
module compacting_list_store
	import cls_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [VALUE_W-1:0]  s_tdata,   // value[31:0]
	input  logic [ACTION_W-1:0] s_tuser,   // action[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_W-1:0]    m_tdata,   // element[31:0], count[36:32], zeros
	output logic [STATUS_W-1:0] m_tuser,   // status[1:0]
	output logic                m_tlast
);

	fsm_t                state_q, state_n;
	logic [CNT_W-1:0]    fill_q, fill_n;
	logic [CNT_W-1:0]    cnt_q, cnt_n;

	logic                m_tvalid_q;
	logic [VALUE_W-1:0]  element_q;
	logic [COUNT_W-1:0]  count_q;
	status_t             status_q;
	logic                last_q;

	logic                load;
	logic [VALUE_W-1:0]  element_n;
	logic [COUNT_W-1:0]  count_n;
	status_t             status_n;
	logic                last_n;

	logic                out_slot;
	logic                s_acc;
	logic                dump_last;
	logic                found;
	action_t             action;
	cell_ctl_t           ctl;

	logic [VALUE_W-1:0]  cell_data [CAPACITY];
	logic [CAPACITY:0]   above;
	logic [CAPACITY:0]   below;

	assign action    = action_t'(s_tuser);
	assign out_slot  = ~m_tvalid_q | m_tready;
	assign s_acc     = s_tvalid & s_tready;
	assign dump_last = (cnt_q == CNT_W'(fill_q - 1'b1));
	assign found     = above[0];

	// Cell chain.
	assign above[CAPACITY] = 1'b0;
	assign below[0]        = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_W-1:0] up;
		if (i == CAPACITY - 1) begin : g_top
			assign up = '0;
		end else begin : g_mid
			assign up = cell_data[i+1];
		end
		cls_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (IDX_W'(i)),
			.up_data   (up),
			.head_data (cell_data[0]),
			.above_in  (above[i+1]),
			.below_in  (below[i]),
			.above_out (above[i]),
			.below_out (below[i+1]),
			.data      (cell_data[i])
		);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (s_acc && action == ACT_DUMP && fill_q != '0)
					state_n = FSM_DUMP;
			end
			FSM_DUMP: begin
				if (out_slot && dump_last)
					state_n = FSM_IDLE;
			end
			default: begin
				state_n = FSM_IDLE;
			end
		endcase
	end

	// Outputs of the controller.
	always_comb begin
		s_tready  = 1'b0;
		ctl.op    = CELL_HOLD;
		ctl.value = s_tdata;
		ctl.fill  = fill_q;
		fill_n    = fill_q;
		cnt_n     = cnt_q;
		load      = 1'b0;
		element_n = '0;
		last_n    = 1'b1;
		status_n  = ST_OK;
		count_n   = COUNT_W'(fill_q);
		case (state_q)
			FSM_IDLE: begin
				s_tready = out_slot;
				if (s_acc) begin
					load = 1'b1;
					case (action)
						ACT_APPEND: begin
							if (fill_q < CNT_W'(CAPACITY)) begin
								ctl.op  = CELL_APPEND;
								fill_n  = fill_q + 1'b1;
								count_n = COUNT_W'(fill_q + 1'b1);
							end else begin
								status_n = ST_FULL;
							end
						end
						ACT_REMOVE: begin
							ctl.op = CELL_REMOVE;
							if (found) begin
								fill_n  = fill_q - 1'b1;
								count_n = COUNT_W'(fill_q - 1'b1);
							end else begin
								status_n = ST_NOTFOUND;
							end
						end
						ACT_DUMP: begin
							cnt_n = '0;
							if (fill_q == '0)
								status_n = ST_EMPTY;
							else
								load = 1'b0;
						end
						default: begin
							status_n = ST_OK;
						end
					endcase
				end
			end
			FSM_DUMP: begin
				if (out_slot) begin
					ctl.op    = CELL_ROTATE;
					load      = 1'b1;
					element_n = cell_data[0];
					last_n    = dump_last;
					cnt_n     = cnt_q + 1'b1;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			fill_q     <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			fill_q  <= fill_n;
			cnt_q   <= cnt_n;
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			element_q <= element_n;
			count_q   <= count_n;
			status_q  <= status_n;
			last_q    <= last_n;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({count_q, element_q});
	assign m_tuser  = status_q;
	assign m_tlast  = last_q;

endmodule

// File: src/cls_checker.sv
// Port-level checks for the compacting list store, bound to the top level.
// Depends on cls_pkg.
module cls_checker
	import cls_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OUT_W-1:0]    m_tdata,
	input logic [STATUS_W-1:0] m_tuser,
	input logic                m_tlast
);

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[36:32] <= COUNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tdata[36:32] == COUNT_W'(CAPACITY)
			&& m_tlast && m_tdata[31:0] == '0)
		else $error("full status with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[36:32] == '0 && m_tlast
			&& m_tdata[31:0] == '0)
		else $error("empty status on a non-empty list");

	// Only a dump produces runs longer than one item, and those are all ok.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser == ST_OK && m_tdata[36:32] != '0)
		else $error("bad status inside a dump run");

endmodule

bind compacting_list_store cls_checker u_cls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// File: dv/tb_compacting_list_store.sv
// Testbench for compacting_list_store: directed, random and back-pressure runs
// checked item by item against a behavioral list predictor. Depends on cls_pkg.
`timescale 1ns / 1ps

module tb_compacting_list_store;
	import cls_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 120;

	typedef struct {
		logic [VALUE_W-1:0] element;
		logic               is_last;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} list_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [VALUE_W-1:0]  s_tdata = '0;
	logic [ACTION_W-1:0] s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic                m_tlast;

	// Predictor state: a plain copy of the list and its length.
	logic [VALUE_W-1:0] list_mem [CAPACITY];
	int                 list_len = 0;
	list_result_t       pending_q[$];

	int  errors = 0;
	int  items_sent = 0;
	int  results_seen = 0;
	int  full_refusals = 0;
	int  missed_removes = 0;
	int  empty_dumps = 0;
	int  idle_cycles = 0;
	bit  tx_gaps_on = 1'b1;
	bit  rx_gaps_on = 1'b1;
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	list_result_t got_r;

	compacting_list_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic void push_result(logic [VALUE_W-1:0] element, logic is_last,
			status_t status, int count);
		list_result_t r;
		r.element = element;
		r.is_last = is_last;
		r.status  = status;
		r.count   = count[COUNT_W-1:0];
		pending_q.push_back(r);
	endfunction

	// Applies one accepted item to the list copy and queues what it must produce.
	function automatic void apply_list_item(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
		int pos;
		pos = -1;
		case (act)
			ACT_APPEND: begin
				if (list_len >= CAPACITY) begin
					full_refusals++;
					push_result('0, 1'b1, ST_FULL, list_len);
				end else begin
					list_mem[list_len] = val;
					list_len++;
					push_result('0, 1'b1, ST_OK, list_len);
				end
			end
			ACT_REMOVE: begin
				for (int i = 0; i < list_len; i++)
					if (list_mem[i] == val) pos = i;
				if (pos < 0) begin
					missed_removes++;
					push_result('0, 1'b1, ST_NOTFOUND, list_len);
				end else begin
					for (int i = pos; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
					push_result('0, 1'b1, ST_OK, list_len);
				end
			end
			ACT_DUMP: begin
				if (list_len == 0) begin
					empty_dumps++;
					push_result('0, 1'b1, ST_EMPTY, 0);
				end else begin
					for (int i = 0; i < list_len; i++)
						push_result(list_mem[i], i + 1 == list_len, ST_OK, list_len);
				end
			end
			default: push_result('0, 1'b1, ST_OK, list_len);
		endcase
	endfunction

	// Input items are predicted before results are checked, so ordering within
	// one edge never matters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) apply_list_item(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				results_seen++;
				got_r.element = m_tdata[VALUE_W-1:0];
				got_r.count   = m_tdata[VALUE_W +: COUNT_W];
				got_r.is_last = m_tlast;
				got_r.status  = status_t'(m_tuser);
				if (pending_q.size() == 0) begin
					$error("result with nothing pending: element %0d status %0d",
						$signed(got_r.element), got_r.status);
					errors++;
				end else begin
					list_result_t want;
					want = pending_q.pop_front();
					if (got_r.element !== want.element) begin
						$error("element: expected %0d, got %0d",
							$signed(want.element), $signed(got_r.element));
						errors++;
					end
					if (got_r.is_last !== want.is_last) begin
						$error("last: expected %0b, got %0b", want.is_last, got_r.is_last);
						errors++;
					end
					if (got_r.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got_r.status);
						errors++;
					end
					if (got_r.count !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, got_r.count);
						errors++;
					end
					if (m_tdata[OUT_W-1:VALUE_W+COUNT_W] !== '0) begin
						$error("padding: expected 0, got %0h",
							m_tdata[OUT_W-1:VALUE_W+COUNT_W]);
						errors++;
					end
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gaps_on) begin
			m_tready <= ($urandom_range(0, 99) >= 7);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Roughly three percent of items get a gap of idle input before them.
	task automatic send_item(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val);
		if (tx_gaps_on && $urandom_range(0, 99) < 3) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50 && list_len > 0) return list_mem[$urandom_range(0, list_len - 1)];
		if (r < 75) return $urandom_range(0, 7);
		if (r < 85) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7fff_ffff;
				2: return 32'h0000_0000;
				default: return 32'hffff_ffff;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [ACTION_W-1:0] pick_action(int append_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < append_pct) return ACT_APPEND;
		if (r < 85) return ACT_REMOVE;
		if (r < 97) return ACT_DUMP;
		return ACT_UNUSED;
	endfunction

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_q.size() != 0) @(posedge clk);
		repeat (CAPACITY + 4) @(posedge clk);
	endtask

	// Empty-list cases, field extremes, duplicates, a miss, the unused code,
	// and a fill to capacity with one refused append.
	task automatic test_directed();
		send_item(ACT_DUMP, '0);
		send_item(ACT_REMOVE, 32'h0000_0005);
		send_item(ACT_APPEND, 32'h8000_0000);
		send_item(ACT_APPEND, 32'h7fff_ffff);
		send_item(ACT_APPEND, 32'h0000_0000);
		send_item(ACT_APPEND, 32'hffff_ffff);
		send_item(ACT_APPEND, 32'haaaa_aaaa);
		send_item(ACT_APPEND, 32'h5555_5555);
		send_item(ACT_APPEND, 32'hffff_ffff);
		send_item(ACT_DUMP, '0);
		// The later of the two equal entries must be the one removed.
		send_item(ACT_REMOVE, 32'hffff_ffff);
		send_item(ACT_REMOVE, 32'h8000_0000);
		send_item(ACT_REMOVE, 32'h1234_5678);
		send_item(ACT_UNUSED, 32'hdead_beef);
		while (list_len < CAPACITY - 1) send_item(ACT_APPEND, $urandom);
		send_item(ACT_APPEND, 32'h0000_0001);
		send_item(ACT_APPEND, 32'h0000_0002);
		send_item(ACT_DUMP, '0);
		wait_drained();
	endtask

	// Random walk over the fill level; blocks alternate between growing and
	// shrinking the list, and one stretch runs with no gaps on either side.
	task automatic test_random_walk(int n_items);
		for (int k = 0; k < n_items; k++) begin
			tx_gaps_on = !(k >= 150 && k < 260);
			rx_gaps_on = tx_gaps_on;
			send_item(pick_action(((k / 40) % 2 == 0) ? 60 : 25), pick_value());
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		wait_drained();
	endtask

	// The receiver stops for a long time while items keep coming, so the
	// store must stall its input and lose nothing.
	task automatic test_output_stall();
		hold_req = 1'b1;
		for (int k = 0; k < 24; k++)
			send_item((k % 4 == 3) ? ACT_DUMP : ACT_APPEND, pick_value());
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_walk(420);
		test_output_stall();
		if (pending_q.size() != 0) begin
			$error("%0d expected results never arrived", pending_q.size());
			errors++;
		end
		$display("run: %0d items in, %0d results checked", items_sent, results_seen);
		$display("cases: %0d full refusals, %0d missed removes, %0d empty dumps",
			full_refusals, missed_removes, empty_dumps);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: compacting_list_store.f
src/cls_pkg.sv
src/cls_cell.sv
src/compacting_list_store.sv
src/cls_checker.sv
dv/tb_compacting_list_store.sv
